// ----- hdl/cat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cat_pkg;
  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CntW = 6;
  localparam logic [7:0] MissMax = 8'd255;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_STALE     = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_MATCH,
    ST_SORT,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic [5:0] channel;
    logic signed [9:0] last;
    logic signed [9:0] peak;
    logic [7:0] misses;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_idx;
    logic inc_idx;
    logic age;       // age entry at idx
    logic upd;       // update entry at idx with sample
    logic app;       // append sample
    logic sort_init; // start sort at i = 1
    logic sort_step;
    logic emit;      // load output register from idx
    logic emit_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       idx_last;    // idx == count-1
    logic       hit;         // entry at idx matches channel
    logic       sample_ok;
    logic       full;
    logic       sort_done;
    logic       out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- hdl/channel_activity_tracker.sv -----
// channel   dir  fields (lsb first)
// s_axis    in   tuser: op[1:0]; tdata: channel[5:0] rssi[15:6]
// m_axis    out  tuser: entry_valid; tdata: entry_channel[5:0] last_strength[15:6]
//                peak_strength[25:16] misses[33:26] stale[34]; tlast: last_of_report
// cfg       in   0 active_threshold, 1 stale_limit
// one item at a time: sweep start and a sample each walk the table before
// the next ready (n entries, at most 32); sweep end runs an insertion sort
// over the table and then emits one result per entry.
// reset clears the table count and control, no clearing pass.
// a stalled result holds the report; no item is taken until the last is gone.
`timescale 1ns / 1ps
`default_nettype none
module channel_activity_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,  // op
  input  wire logic [15:0] s_axis_tdata,  // channel, rssi
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic             m_axis_tuser,  // entry_valid
  output logic [39:0]      m_axis_tdata,  // entry_channel, last, peak, misses, stale
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i
);
  cat_pkg::cmd_t cmd;
  cat_pkg::sts_t sts;
  logic idle;
  logic signed [9:0] thr_q;
  logic [7:0] stale_q;
  logic [36:0] dp_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= -10'sd200;
      stale_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cat_pkg::reg_e'(cfg_idx_i))
        cat_pkg::REG_THRESHOLD: thr_q <= $signed(cfg_data_i);
        cat_pkg::REG_STALE:     stale_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = idle && !m_axis_tvalid;

  cat_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .sts_i(sts), .idle_o(idle), .cmd_o(cmd)
  );

  cat_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .op_i(s_axis_tuser), .channel_i(s_axis_tdata[5:0]),
    .rssi_i(s_axis_tdata[15:6]), .threshold_i(thr_q), .stale_limit_i(stale_q),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_data_o(dp_out), .sts_o(sts)
  );

  assign m_axis_tuser = dp_out[0];
  assign m_axis_tdata = {5'd0, dp_out[35:1]};
  assign m_axis_tlast = dp_out[36];
endmodule
`default_nettype wire

// ----- hdl/cat_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cat_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_fire_i,
  input  cat_pkg::sts_t     sts_i,
  output logic              idle_o,
  output cat_pkg::cmd_t     cmd_o
);
  cat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cat_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // raised in the cycle after capture, so sts_i.op is the item's op
  logic start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else         start_q <= in_fire_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cat_pkg::ST_IDLE: begin
        if (start_q) begin
          unique case (cat_pkg::op_e'(sts_i.op))
            cat_pkg::OP_START:  state_d = sts_i.count_zero ? cat_pkg::ST_IDLE
                                                           : cat_pkg::ST_AGE;
            cat_pkg::OP_SAMPLE: state_d = cat_pkg::ST_MATCH;
            cat_pkg::OP_END:    state_d = sts_i.count_zero ? cat_pkg::ST_EMPTY
                                                           : cat_pkg::ST_SORT;
            default:            state_d = cat_pkg::ST_IDLE;
          endcase
        end
      end
      cat_pkg::ST_AGE:   if (sts_i.idx_last) state_d = cat_pkg::ST_IDLE;
      cat_pkg::ST_MATCH: begin
        if (!sts_i.sample_ok || sts_i.hit || sts_i.count_zero || sts_i.idx_last)
          state_d = cat_pkg::ST_IDLE;
      end
      cat_pkg::ST_SORT:  if (sts_i.sort_done) state_d = cat_pkg::ST_EMIT;
      cat_pkg::ST_EMIT:  if (!sts_i.out_busy && sts_i.idx_last) state_d = cat_pkg::ST_IDLE;
      cat_pkg::ST_EMPTY: if (!sts_i.out_busy) state_d = cat_pkg::ST_IDLE;
      default:           state_d = cat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    idle_o = (state_q == cat_pkg::ST_IDLE) && !start_q;
    cmd_o.load = in_fire_i;
    unique case (state_q)
      cat_pkg::ST_IDLE: begin
        cmd_o.clr_idx = 1'b1;
        cmd_o.sort_init = 1'b1;
      end
      cat_pkg::ST_AGE: begin
        cmd_o.age = 1'b1;
        cmd_o.inc_idx = 1'b1;
      end
      cat_pkg::ST_MATCH: begin
        if (sts_i.sample_ok) begin
          if (!sts_i.count_zero && sts_i.hit) cmd_o.upd = 1'b1;
          else if ((sts_i.count_zero || sts_i.idx_last) && !sts_i.full) cmd_o.app = 1'b1;
          cmd_o.inc_idx = 1'b1;
        end
      end
      cat_pkg::ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        cmd_o.clr_idx = sts_i.sort_done;
      end
      cat_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.inc_idx = 1'b1;
        end
      end
      cat_pkg::ST_EMPTY: cmd_o.emit_empty = !sts_i.out_busy;
      default: ;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.age, cmd_o.upd, cmd_o.app, cmd_o.emit, cmd_o.emit_empty}))
    else $error("conflicting datapath commands");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == cat_pkg::ST_IDLE && !start_q)
    else $error("item taken while busy");
  a_sort_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cat_pkg::ST_EMIT) |-> $past(state_q) == cat_pkg::ST_SORT
                                      || $past(state_q) == cat_pkg::ST_EMIT)
    else $error("report without sort");
endmodule
`default_nettype wire

// ----- hdl/cat_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cat_datapath (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  cat_pkg::cmd_t     cmd_i,
  input  wire logic [1:0]   op_i,
  input  wire logic [5:0]   channel_i,
  input  wire logic signed [9:0] rssi_i,
  input  wire logic signed [9:0] threshold_i,
  input  wire logic [7:0]   stale_limit_i,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic [36:0]       out_data_o,
  output cat_pkg::sts_t     sts_o
);
  // table kept in flip-flops: the sort touches neighbouring pairs
  cat_pkg::entry_t tab_q [cat_pkg::Capacity];
  logic [cat_pkg::CntW-1:0] cnt_q;
  logic [cat_pkg::CntW-1:0] idx_q;
  logic [cat_pkg::CntW-1:0] si_q, sj_q;   // insertion sort outer and inner
  logic [1:0] op_q;
  logic [5:0] ch_q;
  logic signed [9:0] rssi_q;
  logic out_valid_q;
  logic [36:0] out_q;

  logic [cat_pkg::IdxW-1:0] ix, jx, jm;
  cat_pkg::entry_t ea, eb, cur;
  logic goes_first;
  logic idx_last;
  assign ix = idx_q[cat_pkg::IdxW-1:0];
  assign jx = sj_q[cat_pkg::IdxW-1:0];
  assign jm = jx - 1'b1;
  assign cur = tab_q[ix];
  assign ea = tab_q[jx];
  assign eb = tab_q[jm];
  assign idx_last = (idx_q + 1'b1) == cnt_q;
  always_comb begin
    if ((ea.misses == 8'd0) != (eb.misses == 8'd0)) goes_first = (ea.misses == 8'd0);
    else goes_first = ea.last > eb.last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      ch_q <= channel_i;
      rssi_q <= rssi_i;
    end
    if (cmd_i.age && cur.misses != cat_pkg::MissMax) tab_q[ix].misses <= cur.misses + 8'd1;
    if (cmd_i.upd) begin
      tab_q[ix].last <= rssi_q;
      if (rssi_q > cur.peak) tab_q[ix].peak <= rssi_q;
      tab_q[ix].misses <= 8'd0;
    end
    if (cmd_i.app) tab_q[cnt_q[cat_pkg::IdxW-1:0]] <= '{ch_q, rssi_q, rssi_q, 8'd0};
    if (cmd_i.sort_step && sj_q != '0 && si_q < cnt_q && goes_first) begin
      tab_q[jx] <= eb;
      tab_q[jm] <= ea;
    end
    if (cmd_i.emit)
      out_q <= {idx_last, cur.misses >= stale_limit_i, cur.misses,
                cur.peak, cur.last, cur.channel, 1'b1};
    else if (cmd_i.emit_empty)
      out_q <= {1'b1, 36'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      si_q <= '0;
      sj_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.app) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.inc_idx) idx_q <= idx_q + 1'b1;
      if (cmd_i.sort_init) begin
        si_q <= 6'd1;
        sj_q <= 6'd1;
      end else if (cmd_i.sort_step && si_q < cnt_q) begin
        if (sj_q != '0 && goes_first) sj_q <= sj_q - 1'b1;
        else begin
          si_q <= si_q + 1'b1;
          sj_q <= si_q + 1'b1;
        end
      end
      if (cmd_i.emit || cmd_i.emit_empty) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign sts_o.op = op_q;
  assign sts_o.count_zero = cnt_q == '0;
  assign sts_o.idx_last = idx_last;
  assign sts_o.hit = cur.channel == ch_q;
  assign sts_o.sample_ok = rssi_q > threshold_i;
  assign sts_o.full = cnt_q == 6'(cat_pkg::Capacity);
  assign sts_o.sort_done = si_q >= cnt_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 6'(cat_pkg::Capacity)) else $error("table count overflow");
  a_app_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.app |=> cnt_q == $past(cnt_q) + 6'd1) else $error("append lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// ----- tb/sv/channel_activity_tracker_tb.sv -----
`timescale 1ns / 1ps
module channel_activity_tracker_tb;

  typedef struct packed {
    logic       valid;
    logic [5:0] channel;
    logic signed [9:0] last;
    logic signed [9:0] peak;
    logic [7:0] misses;
    logic       stale;
    logic       last_of_report;
  } report_t;

  class activity_board;
    logic signed [9:0] threshold;
    logic [7:0]        stale_limit;
    cat_pkg::entry_t   table_q[$];
    report_t           pending_q[$];
    int                errors;

    function void reset_state();
      threshold = -10'sd200;
      stale_limit = 8'd3;
      table_q.delete();
      pending_q.delete();
      errors = 0;
    endfunction

    function void write_reg(cat_pkg::reg_e idx, logic [9:0] val);
      if (idx == cat_pkg::REG_THRESHOLD) threshold = val;
      else stale_limit = val[7:0];
    endfunction

    function bit precedes(cat_pkg::entry_t a, cat_pkg::entry_t b);
      if ((a.misses == 0) != (b.misses == 0)) return a.misses == 0;
      return a.last > b.last;
    endfunction

    function void note_item(cat_pkg::op_e op, logic [5:0] ch, logic signed [9:0] rssi);
      cat_pkg::entry_t e, t;
      int j;
      bit hit;
      report_t r;
      case (op)
        cat_pkg::OP_START: begin
          foreach (table_q[i])
            if (table_q[i].misses != cat_pkg::MissMax) table_q[i].misses++;
        end
        cat_pkg::OP_SAMPLE: begin
          if (rssi > threshold) begin
            hit = 0;
            foreach (table_q[i])
              if (!hit && table_q[i].channel == ch) begin
                hit = 1;
                table_q[i].last = rssi;
                if (rssi > table_q[i].peak) table_q[i].peak = rssi;
                table_q[i].misses = 0;
              end
            if (!hit && table_q.size() < cat_pkg::Capacity) begin
              e.channel = ch; e.last = rssi; e.peak = rssi; e.misses = 0;
              table_q.push_back(e);
            end
          end
        end
        cat_pkg::OP_END: begin
          if (table_q.size() == 0) begin
            r = '0; r.last_of_report = 1;
            pending_q.push_back(r);
          end else begin
            // stable insertion sort: active first, then stronger last rssi
            for (int i = 1; i < table_q.size(); i++) begin
              j = i;
              while (j > 0 && precedes(table_q[j], table_q[j-1])) begin
                t = table_q[j]; table_q[j] = table_q[j-1]; table_q[j-1] = t;
                j--;
              end
            end
            foreach (table_q[i]) begin
              r.valid = 1; r.channel = table_q[i].channel;
              r.last = table_q[i].last; r.peak = table_q[i].peak;
              r.misses = table_q[i].misses;
              r.stale = table_q[i].misses >= stale_limit;
              r.last_of_report = (i == table_q.size() - 1);
              pending_q.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(report_t got);
      report_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected v%0d ch%0d last%0d peak%0d m%0d s%0d l%0d",
                 $time, exp.valid, exp.channel, exp.last, exp.peak, exp.misses,
                 exp.stale, exp.last_of_report);
        $display("%0t:          actual v%0d ch%0d last%0d peak%0d m%0d s%0d l%0d",
                 $time, got.valid, got.channel, got.last, got.peak, got.misses,
                 got.stale, got.last_of_report);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic        m_axis_tuser;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 0;
  logic [0:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  activity_board board = new();
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent
  bit hold_off = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  channel_activity_tracker dut (.*);

  function automatic report_t unpack_result(logic user, logic [39:0] data, logic lst);
    report_t r;
    r.valid = user;
    r.channel = data[5:0];
    r.last = data[15:6];
    r.peak = data[25:16];
    r.misses = data[33:26];
    r.stale = data[34];
    r.last_of_report = lst;
    return r;
  endfunction

  // result side and watchdog
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_result(unpack_result(m_axis_tuser, m_axis_tdata, m_axis_tlast));
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(cat_pkg::op_e op, logic [5:0] ch, logic signed [9:0] rssi);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {rssi, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(op, ch, rssi);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    // a trailing sample or sweep start may still be running
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_cfg(cat_pkg::reg_e idx, logic [9:0] val);
    drain();
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic random_sweep(int samples, int span);
    send_item(cat_pkg::OP_START, 0, 0);
    repeat (samples) begin
      case ($urandom_range(19))
        0: send_item(cat_pkg::OP_NONE, 6'($urandom), 10'($urandom));
        1: send_item(cat_pkg::OP_START, 6'($urandom), 10'($urandom));
        default: send_item(cat_pkg::OP_SAMPLE, 6'($urandom_range(span)), 10'($urandom));
      endcase
    end
    send_item(cat_pkg::OP_END, 6'($urandom), 10'($urandom));
  endtask

  initial begin
    board.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, extremes, thresholds, fill past capacity
    send_item(cat_pkg::OP_END, 0, 0);
    send_item(cat_pkg::OP_NONE, 6'd63, 10'sd511);
    send_item(cat_pkg::OP_SAMPLE, 6'd0, -10'sd200);
    send_item(cat_pkg::OP_SAMPLE, 6'd63, 10'sd511);
    send_item(cat_pkg::OP_SAMPLE, 6'd5, -10'sd199);
    send_item(cat_pkg::OP_SAMPLE, 6'd63, -10'sd100);
    send_item(cat_pkg::OP_START, 6'd63, -10'sd512);
    send_item(cat_pkg::OP_END, 6'd0, 0);
    write_cfg(cat_pkg::REG_THRESHOLD, 10'h200);
    write_cfg(cat_pkg::REG_STALE, 10'd1);
    send_item(cat_pkg::OP_SAMPLE, 6'd7, -10'sd511);
    send_item(cat_pkg::OP_START, 0, 0);
    send_item(cat_pkg::OP_END, 0, 0);
    for (int i = 0; i < 34; i++)
      send_item(cat_pkg::OP_SAMPLE, 6'(i + 20), 10'($urandom));
    send_item(cat_pkg::OP_END, 0, 0);

    // misses climb with the stale limit at its top, then at zero
    write_cfg(cat_pkg::REG_STALE, 10'd255);
    repeat (6) send_item(cat_pkg::OP_START, 0, 0);
    send_item(cat_pkg::OP_END, 0, 0);
    write_cfg(cat_pkg::REG_STALE, 10'd0);
    send_item(cat_pkg::OP_END, 0, 0);
    write_cfg(cat_pkg::REG_THRESHOLD, 10'h1ff);
    send_item(cat_pkg::OP_SAMPLE, 6'd1, 10'sd511);
    send_item(cat_pkg::OP_END, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      write_cfg(cat_pkg::REG_THRESHOLD, 10'($urandom_range(100, 350) + 10'h200));
      write_cfg(cat_pkg::REG_STALE, 10'($urandom_range(1, 5)));
      random_sweep(13, $urandom_range(1) ? 15 : 63);
      random_sweep(13, 10);
    end

    // long receiver hold-off while items keep coming
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off <= 1;
        repeat (400) @(posedge clk_i);
        hold_off <= 0;
      end
      begin
        send_item(cat_pkg::OP_END, 0, 0);
        send_item(cat_pkg::OP_SAMPLE, 6'd3, 10'sd300);
        send_item(cat_pkg::OP_END, 0, 0);
        s_axis_tvalid <= 0;
      end
    join

    drain();
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
